// ----- src/pmre_pkg.sv -----
// Shared types and field widths for the polyline miter ribbon expander.
`timescale 1ns / 1ps

package pmre_pkg;

    localparam int COORD_W  = 16;
    localparam int VTX_W    = 21;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 32;
    localparam int LWIDTH_W = 12;

    // One segment job handed from the front to the back.
    typedef struct packed {
        logic signed [COORD_W-1:0] held_x;
        logic signed [COORD_W-1:0] held_y;
        logic signed [COORD_W-1:0] pt_x;
        logic signed [COORD_W-1:0] pt_y;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic                      first;
        logic                      last;
    } cmd_t;

    // One vertex pair as it leaves the block.
    typedef struct packed {
        logic signed [VTX_W-1:0] left_x;
        logic signed [VTX_W-1:0] left_y;
        logic signed [VTX_W-1:0] right_x;
        logic signed [VTX_W-1:0] right_y;
        logic [COLOR_W-1:0]      red;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      blue;
        logic [INDEX_W-1:0]      left_index;
        logic                    strip_end;
    } res_t;

endpackage

// ----- src/pmre_fifo.sv -----
// Small register FIFO used for the job queue and the result queue.
`timescale 1ns / 1ps

module pmre_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- src/pmre_sqrt.sv -----
// Bit-pair integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module pmre_sqrt #(
    parameter int RW = 46
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [RW-1:0]   radicand,
    output logic            done,
    output logic [RW/2-1:0] root
);

    localparam int HW = RW / 2;

    logic [RW-1:0] v_reg, v_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] b_reg, b_next;
    logic [RW-1:0] trial;
    logic          run_reg, run_next;
    logic          done_reg, done_next;

    assign trial = r_reg + b_reg;
    assign done  = done_reg;
    assign root  = r_reg[HW-1:0];

    always_comb
    begin
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next   = radicand;
            r_next   = '0;
            b_next   = {2'b01, {(RW-2){1'b0}}};
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            // The bit has reached weight one: this was the final step.
            if (b_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

endmodule

// ----- src/pmre_div.sv -----
// Restoring divider, one quotient bit per cycle, for quotients below 2^QB.
`timescale 1ns / 1ps

module pmre_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 30,
    parameter int QB    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QB-1:0]    quo
);

    localparam int IW  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;
    localparam int CNW = $clog2(QB + 1);

    logic [IW-1:0]  rem_reg, rem_next;
    logic [IW-1:0]  dsh_reg, dsh_next;
    logic [QB-1:0]  q_reg, q_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;

    assign done = done_reg;
    assign quo  = q_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = IW'(num);
            dsh_next = IW'(den) << (QB - 1);
            q_next   = '0;
            cnt_next = CNW'(QB);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QB-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

endmodule

// ----- src/pmre_front.sv -----
// Front end: accepts points, tracks route progress and issues segment jobs.
`timescale 1ns / 1ps

module pmre_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [pmre_pkg::COORD_W-1:0]  point_x,
    input  logic signed [pmre_pkg::COORD_W-1:0]  point_y,
    input  logic [pmre_pkg::COLOR_W-1:0]         color_red,
    input  logic [pmre_pkg::COLOR_W-1:0]         color_green,
    input  logic [pmre_pkg::COLOR_W-1:0]         color_blue,
    input  logic                                 last_point,
    input  logic                                 cmd_full,
    output logic                                 cmd_push,
    output pmre_pkg::cmd_t                       cmd
);

    import pmre_pkg::*;

    typedef enum logic [2:0] {
        RT_START = 3'b001,
        RT_ONE   = 3'b010,
        RT_MORE  = 3'b100
    } route_t;

    route_t                    route_reg, route_next;
    logic signed [COORD_W-1:0] held_x_reg, held_y_reg;
    logic [COLOR_W-1:0]        red_reg, green_reg, blue_reg;
    logic                      accept;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept && (route_reg != RT_START);

    always_comb
    begin
        cmd.held_x = held_x_reg;
        cmd.held_y = held_y_reg;
        cmd.pt_x   = point_x;
        cmd.pt_y   = point_y;
        cmd.red    = red_reg;
        cmd.green  = green_reg;
        cmd.blue   = blue_reg;
        cmd.first  = (route_reg == RT_ONE);
        cmd.last   = last_point;
    end

    always_comb
    begin
        route_next = route_reg;
        if (accept)
        begin
            case (route_reg)
                RT_START: route_next = last_point ? RT_START : RT_ONE;
                RT_ONE:   route_next = last_point ? RT_START : RT_MORE;
                RT_MORE:  route_next = last_point ? RT_START : RT_MORE;
                default:  route_next = RT_START;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_reg  <= RT_START;
            held_x_reg <= '0;
            held_y_reg <= '0;
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
        end
        else
        begin
            route_reg <= route_next;
            if (accept)
            begin
                held_x_reg <= point_x;
                held_y_reg <= point_y;
                // The route takes its color from its first point.
                if (route_reg == RT_START)
                begin
                    red_reg   <= color_red;
                    green_reg <= color_green;
                    blue_reg  <= color_blue;
                end
            end
        end
    end

endmodule

// ----- src/pmre_back.sv -----
// Back end: normals, miter selection and vertex pair generation per segment job.
`timescale 1ns / 1ps

module pmre_back #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_pop,
    input  pmre_pkg::cmd_t                       cmd,
    input  logic [pmre_pkg::LWIDTH_W-1:0]        stroke_width,
    input  logic                                 res_full,
    output logic                                 res_push,
    output pmre_pkg::res_t                       res
);

    import pmre_pkg::*;

    localparam int F    = NORMAL_FRAC_BITS;
    localparam int NW   = F + 2;
    localparam int VW   = (F + 3 > 17) ? F + 3 : 17;
    localparam int MW   = VW - 1;
    localparam int SW   = 2 * MW + 1;
    localparam int RW   = 2 * MW + 14;
    localparam int LW   = RW / 2;
    localparam int QB   = (F + 2 > 15) ? F + 2 : 15;
    localparam int PW   = NW + LWIDTH_W;
    localparam int CW   = 2 * NW + 1;
    localparam int UNUM = MW + F + 7;
    localparam int MNUM = PW + F + 1;
    localparam int DNUM = (UNUM > MNUM) ? UNUM : MNUM;
    localparam int DDEN = (LW > CW + 1) ? LW : CW + 1;
    localparam int OW   = 16;
    localparam logic signed [CW-1:0] C_QUARTER = CW'(64'd1 << (2 * F - 2));
    localparam logic [PW+2:0]        HALF_END  = (PW+3)'(64'd1 << F);

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_DIFF  = 20'h00002,
        ST_SQX   = 20'h00004,
        ST_SQY   = 20'h00008,
        ST_SUM   = 20'h00010,
        ST_ROOT  = 20'h00020,
        ST_DXG   = 20'h00040,
        ST_DXW   = 20'h00080,
        ST_DYG   = 20'h00100,
        ST_DYW   = 20'h00200,
        ST_SEGD  = 20'h00400,
        ST_MITD  = 20'h00800,
        ST_DOT1  = 20'h01000,
        ST_DOT2  = 20'h02000,
        ST_DOTS  = 20'h04000,
        ST_PMUL  = 20'h08000,
        ST_PSCL  = 20'h10000,
        ST_PDIV  = 20'h20000,
        ST_PEMIT = 20'h40000,
        ST_AFTER = 20'h80000
    } state_t;

    typedef enum logic [2:0] {
        KIND_UNIT  = 3'b001,
        KIND_SHARP = 3'b010,
        KIND_MITER = 3'b100
    } kind_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic                   phase_reg, phase_next;
    logic signed [VW-1:0]   vx_reg, vx_next, vy_reg, vy_next;
    logic [2*MW-1:0]        sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [LW-1:0]          l_reg, l_next;
    logic signed [NW-1:0]   ux_reg, ux_next, uy_reg, uy_next;
    logic signed [NW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic signed [NW-1:0]   prior_x_reg, prior_x_next, prior_y_reg, prior_y_next;
    logic signed [2*NW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic signed [CW-1:0]   c_reg, c_next;
    logic signed [NW-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    kind_t                  kind_reg, kind_next;
    logic                   end_reg, end_next;
    logic                   axis_reg, axis_next;
    logic signed [COORD_W-1:0] ptx_reg, ptx_next, pty_reg, pty_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic signed [OW-1:0]   offx_reg, offx_next, offy_reg, offy_next;
    logic [INDEX_W-1:0]     vcount_reg, vcount_next;

    logic [MW-1:0]          ax, ay, sq_in, uv_mag;
    logic [2*MW-1:0]        sq_prod;
    logic [SW-1:0]          s_sum;
    logic                   sq_start, sq_done;
    logic [RW-1:0]          sq_rad;
    logic [LW-1:0]          sq_root;
    logic                   div_start, div_done;
    logic [DNUM-1:0]        div_num;
    logic [DDEN-1:0]        div_den;
    logic [QB-1:0]          div_quo;
    logic signed [NW:0]     tx, ty;
    logic signed [CW-1:0]   c_sum;
    logic signed [NW-1:0]   n_sel;
    logic [NW-1:0]          n_mag;
    logic [PW+2:0]          scaled, rounded;
    logic [OW-1:0]          off_mag, div_off;
    logic signed [OW-1:0]   off_val, div_val;
    logic signed [NW-1:0]   q_pos;
    logic signed [21:0]     cx, cy, ox, oy;
    logic signed [21:0]     lx, ly, rx, ry;

    assign ax = MW'(vx_reg[VW-1] ? -vx_reg : vx_reg);
    assign ay = MW'(vy_reg[VW-1] ? -vy_reg : vy_reg);
    assign sq_in   = (state_reg == ST_SQY) ? ay : ax;
    assign sq_prod = (2*MW)'(sq_in) * (2*MW)'(sq_in);
    assign s_sum   = SW'(sqx_reg) + SW'(sqy_reg);
    assign sq_rad  = RW'({s_sum, 12'b0});
    assign sq_start = (state_reg == ST_SUM) && (s_sum != '0);

    assign uv_mag = (state_reg == ST_DYG) ? ay : ax;
    assign div_start = (state_reg == ST_DXG) || (state_reg == ST_DYG)
                       || ((state_reg == ST_PSCL) && (kind_reg == KIND_MITER));
    assign div_num = (state_reg == ST_PSCL)
                     ? DNUM'({prod_reg, {F{1'b0}}}) + DNUM'(c_reg)
                     : DNUM'({uv_mag, {(F+6){1'b0}}}) + DNUM'(l_reg >> 1);
    assign div_den = (state_reg == ST_PSCL) ? DDEN'({c_reg, 1'b0}) : DDEN'(l_reg);
    assign q_pos   = NW'(div_quo);

    assign tx    = (NW+1)'(prior_x_reg) - (NW+1)'(uy_reg);
    assign ty    = (NW+1)'(prior_y_reg) + (NW+1)'(ux_reg);
    assign c_sum = CW'(p1_reg) + CW'(p2_reg);

    assign n_sel   = axis_reg ? ny_reg : nx_reg;
    assign n_mag   = NW'(n_sel[NW-1] ? -n_sel : n_sel);
    assign scaled  = (kind_reg == KIND_SHARP) ? (PW+3)'({prod_reg, 2'b00})
                                              : (PW+3)'(prod_reg);
    assign rounded = scaled + HALF_END;
    assign off_mag = OW'(rounded >> (F + 1));
    assign off_val = n_sel[NW-1] ? -off_mag : off_mag;
    assign div_off = OW'(div_quo);
    assign div_val = n_sel[NW-1] ? -div_off : div_off;

    assign cx = {{2{ptx_reg[COORD_W-1]}}, ptx_reg, 4'b0};
    assign cy = {{2{pty_reg[COORD_W-1]}}, pty_reg, 4'b0};
    assign ox = 22'(offx_reg);
    assign oy = 22'(offy_reg);
    assign lx = cx + ox;
    assign ly = cy + oy;
    assign rx = cx - ox;
    assign ry = cy - oy;

    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign res_push = (state_reg == ST_PEMIT) && !res_full;

    always_comb
    begin
        res.left_x     = lx[VTX_W-1:0];
        res.left_y     = ly[VTX_W-1:0];
        res.right_x    = rx[VTX_W-1:0];
        res.right_y    = ry[VTX_W-1:0];
        res.red        = cmd_reg.red;
        res.green      = cmd_reg.green;
        res.blue       = cmd_reg.blue;
        res.left_index = vcount_reg;
        res.strip_end  = end_reg;
    end

    pmre_sqrt #(
        .RW(RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    pmre_div #(
        .NUM_W (DNUM),
        .DEN_W (DDEN),
        .QB    (QB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        phase_next   = phase_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        sqx_next     = sqx_reg;
        sqy_next     = sqy_reg;
        l_next       = l_reg;
        ux_next      = ux_reg;
        uy_next      = uy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        prior_x_next = prior_x_reg;
        prior_y_next = prior_y_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        c_next       = c_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        kind_next    = kind_reg;
        end_next     = end_reg;
        axis_next    = axis_reg;
        ptx_next     = ptx_reg;
        pty_next     = pty_reg;
        prod_next    = prod_reg;
        offx_next    = offx_reg;
        offy_next    = offy_reg;
        vcount_next  = vcount_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                vx_next    = VW'(cmd_reg.pt_x) - VW'(cmd_reg.held_x);
                vy_next    = VW'(cmd_reg.pt_y) - VW'(cmd_reg.held_y);
                phase_next = 1'b0;
                state_next = ST_SQX;
            end
            ST_SQX:
            begin
                sqx_next   = sq_prod;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                sqy_next   = sq_prod;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (s_sum == '0)
                begin
                    // A zero-length vector normalizes to zero.
                    ux_next    = '0;
                    uy_next    = '0;
                    state_next = phase_reg ? ST_MITD : ST_SEGD;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sq_done)
                begin
                    l_next     = sq_root;
                    state_next = ST_DXG;
                end
            end
            ST_DXG:
            begin
                state_next = ST_DXW;
            end
            ST_DXW:
            begin
                if (div_done)
                begin
                    ux_next    = vx_reg[VW-1] ? -q_pos : q_pos;
                    state_next = ST_DYG;
                end
            end
            ST_DYG:
            begin
                state_next = ST_DYW;
            end
            ST_DYW:
            begin
                if (div_done)
                begin
                    uy_next    = vy_reg[VW-1] ? -q_pos : q_pos;
                    state_next = phase_reg ? ST_MITD : ST_SEGD;
                end
            end
            ST_SEGD:
            begin
                // Left normal of the segment is (-uy, ux).
                sx_next   = -uy_reg;
                sy_next   = ux_reg;
                ptx_next  = cmd_reg.held_x;
                pty_next  = cmd_reg.held_y;
                end_next  = 1'b0;
                axis_next = 1'b0;
                kind_next = KIND_UNIT;
                if (cmd_reg.first)
                begin
                    nx_next    = -uy_reg;
                    ny_next    = ux_reg;
                    state_next = ST_PMUL;
                end
                else if ((tx == '0) && (ty == '0))
                begin
                    // U-turn: keep the incoming normal at unit scale.
                    nx_next    = prior_x_reg;
                    ny_next    = prior_y_reg;
                    state_next = ST_PMUL;
                end
                else
                begin
                    vx_next    = VW'(tx);
                    vy_next    = VW'(ty);
                    phase_next = 1'b1;
                    state_next = ST_SQX;
                end
            end
            ST_MITD:
            begin
                nx_next    = ux_reg;
                ny_next    = uy_reg;
                state_next = ST_DOT1;
            end
            ST_DOT1:
            begin
                p1_next    = (2*NW)'(ux_reg) * (2*NW)'(prior_x_reg);
                state_next = ST_DOT2;
            end
            ST_DOT2:
            begin
                p2_next    = (2*NW)'(uy_reg) * (2*NW)'(prior_y_reg);
                state_next = ST_DOTS;
            end
            ST_DOTS:
            begin
                c_next     = c_sum;
                kind_next  = (c_sum <= C_QUARTER) ? KIND_SHARP : KIND_MITER;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                if (stroke_width == '0)
                begin
                    state_next = ST_AFTER;
                end
                else
                begin
                    prod_next  = PW'(n_mag) * PW'(stroke_width);
                    state_next = ST_PSCL;
                end
            end
            ST_PSCL:
            begin
                if (kind_reg == KIND_MITER)
                begin
                    state_next = ST_PDIV;
                end
                else
                begin
                    if (axis_reg)
                    begin
                        offy_next  = off_val;
                        state_next = ST_PEMIT;
                    end
                    else
                    begin
                        offx_next  = off_val;
                        axis_next  = 1'b1;
                        state_next = ST_PMUL;
                    end
                end
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        offy_next  = div_val;
                        state_next = ST_PEMIT;
                    end
                    else
                    begin
                        offx_next  = div_val;
                        axis_next  = 1'b1;
                        state_next = ST_PMUL;
                    end
                end
            end
            ST_PEMIT:
            begin
                if (!res_full)
                begin
                    vcount_next = vcount_reg + INDEX_W'(2);
                    state_next  = ST_AFTER;
                end
            end
            ST_AFTER:
            begin
                if (end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    prior_x_next = sx_reg;
                    prior_y_next = sy_reg;
                    if (cmd_reg.last)
                    begin
                        ptx_next   = cmd_reg.pt_x;
                        pty_next   = cmd_reg.pt_y;
                        nx_next    = sx_reg;
                        ny_next    = sy_reg;
                        kind_next  = KIND_UNIT;
                        end_next   = 1'b1;
                        axis_next  = 1'b0;
                        state_next = ST_PMUL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
            vcount_reg  <= '0;
            end_reg     <= 1'b0;
            axis_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            kind_reg    <= KIND_UNIT;
        end
        else
        begin
            state_reg   <= state_next;
            prior_x_reg <= prior_x_next;
            prior_y_reg <= prior_y_next;
            vcount_reg  <= vcount_next;
            end_reg     <= end_next;
            axis_reg    <= axis_next;
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        l_reg    <= l_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        c_reg    <= c_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        ptx_reg  <= ptx_next;
        pty_reg  <= pty_next;
        prod_reg <= prod_next;
        offx_reg <= offx_next;
        offy_reg <= offy_next;
    end

endmodule

// ----- src/polyline_miter_ribbon_expander.sv -----
// Top level of the polyline miter ribbon expander.
`timescale 1ns / 1ps

// Points go in through a queue-style push/full port and vertex pairs come out
// through an empty/pop port; the first point of a route produces nothing, each
// later point releases the pair of the point before it, and a route's last
// point also releases its own pair, marked with strip_end. Work is done one
// segment at a time by a back end that shares a single square-root unit (one
// root bit per cycle) and a single divider (one quotient bit per cycle, for
// quotients of max(NORMAL_FRAC_BITS+2, 15) bits). A short job queue lets the
// next points be taken while the back end works on a segment. No pairs are
// released while the stroke_width register holds zero. The stroke_width
// register may only be written while no point is in flight.
module polyline_miter_ribbon_expander #(
    parameter int NORMAL_FRAC_BITS = 14,
    parameter int CMD_DEPTH        = 2,
    parameter int RES_DEPTH        = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [pmre_pkg::COORD_W-1:0]  point_x,
    input  logic signed [pmre_pkg::COORD_W-1:0]  point_y,
    input  logic [pmre_pkg::COLOR_W-1:0]         color_red,
    input  logic [pmre_pkg::COLOR_W-1:0]         color_green,
    input  logic [pmre_pkg::COLOR_W-1:0]         color_blue,
    input  logic                                 last_point,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [pmre_pkg::VTX_W-1:0]    left_x,
    output logic signed [pmre_pkg::VTX_W-1:0]    left_y,
    output logic signed [pmre_pkg::VTX_W-1:0]    right_x,
    output logic signed [pmre_pkg::VTX_W-1:0]    right_y,
    output logic [pmre_pkg::COLOR_W-1:0]         out_red,
    output logic [pmre_pkg::COLOR_W-1:0]         out_green,
    output logic [pmre_pkg::COLOR_W-1:0]         out_blue,
    output logic [pmre_pkg::INDEX_W-1:0]         left_index,
    output logic                                 strip_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmre_pkg::LWIDTH_W-1:0]        stroke_width
);

    import pmre_pkg::*;

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    logic [LWIDTH_W-1:0] stroke_width_reg;
    logic                cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t                cmd_in, cmd_out;
    logic [CMD_W-1:0]    cmd_dout;
    logic                res_push, res_full;
    res_t                res_in, res_out;
    logic [RES_W-1:0]    res_dout;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stroke_width_reg <= LWIDTH_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            stroke_width_reg <= stroke_width;
        end
    end

    pmre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .point_x     (point_x),
        .point_y     (point_y),
        .color_red   (color_red),
        .color_green (color_green),
        .color_blue  (color_blue),
        .last_point  (last_point),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    pmre_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_dout),
        .empty (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_dout);

    pmre_back #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (!cmd_empty),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd_out),
        .stroke_width (stroke_width_reg),
        .res_full     (res_full),
        .res_push     (res_push),
        .res          (res_in)
    );

    pmre_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign res_out    = res_t'(res_dout);
    assign left_x     = res_out.left_x;
    assign left_y     = res_out.left_y;
    assign right_x    = res_out.right_x;
    assign right_y    = res_out.right_y;
    assign out_red    = res_out.red;
    assign out_green  = res_out.green;
    assign out_blue   = res_out.blue;
    assign left_index = res_out.left_index;
    assign strip_end  = res_out.strip_end;

endmodule

// ----- src/pmre_checker.sv -----
// Port-level checks for the ribbon expander and their binding to the top level.
`timescale 1ns / 1ps

module pmre_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 empty,
    input logic                                 pop,
    input logic signed [pmre_pkg::VTX_W-1:0]    left_x,
    input logic signed [pmre_pkg::VTX_W-1:0]    left_y,
    input logic signed [pmre_pkg::VTX_W-1:0]    right_x,
    input logic signed [pmre_pkg::VTX_W-1:0]    right_y,
    input logic [pmre_pkg::INDEX_W-1:0]         left_index
);

    import pmre_pkg::*;

    logic [INDEX_W-1:0] exp_idx_reg;
    logic [VTX_W-1:0]   sum_x, sum_y;

    // Both vertices sit symmetric about a whole-pixel point.
    assign sum_x = left_x + right_x;
    assign sum_y = left_y + right_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (pop && !empty)
        begin
            exp_idx_reg <= exp_idx_reg + INDEX_W'(2);
        end
    end

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(left_x) && $stable(left_index)))
        else $error("waiting word changed before it was taken");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |-> (left_index == exp_idx_reg))
        else $error("vertex index does not advance by two per word");

    a_center_x: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sum_x[4:0] == 5'd0))
        else $error("x vertices not symmetric about a pixel center");

    a_center_y: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (sum_y[4:0] == 5'd0))
        else $error("y vertices not symmetric about a pixel center");

endmodule

bind polyline_miter_ribbon_expander pmre_checker u_pmre_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .left_x     (left_x),
    .left_y     (left_y),
    .right_x    (right_x),
    .right_y    (right_y),
    .left_index (left_index)
);
